// File: hw/rtl/sbt_pkg.sv
// shared types and constants for the source byte tokenizer
`default_nettype none
package sbt_pkg;
	localparam logic [1:0] RK_TEXT  = 2'd0;
	localparam logic [1:0] RK_TOKEN = 2'd1;
	localparam logic [1:0] RK_ERROR = 2'd2;

	localparam logic [5:0] T_ASSIGN    = 6'd10;
	localparam logic [5:0] T_EQEQ      = 6'd11;
	localparam logic [5:0] T_BANGEQ    = 6'd12;
	localparam logic [5:0] T_LESS      = 6'd13;
	localparam logic [5:0] T_LESSEQ    = 6'd14;
	localparam logic [5:0] T_GREATER   = 6'd15;
	localparam logic [5:0] T_GREATEREQ = 6'd16;
	localparam logic [5:0] T_IDENT     = 6'd17;
	localparam logic [5:0] T_INT       = 6'd18;
	localparam logic [5:0] T_FLOAT     = 6'd19;
	localparam logic [5:0] T_STRING    = 6'd20;
	localparam logic [5:0] T_KW0       = 6'd21;
	localparam logic [5:0] T_EOF       = 6'd33;

	localparam logic       EC_UNKNOWN = 1'b0;
	localparam logic       EC_UNTERM  = 1'b1;

	localparam int NUM_KW = 12;

	function automatic logic [3:0] kw_len(input int k);
		begin
			case (k)
				0:  kw_len = 4'd8;
				1:  kw_len = 4'd6;
				2:  kw_len = 4'd2;
				3:  kw_len = 4'd4;
				4:  kw_len = 4'd3;
				5:  kw_len = 4'd4;
				6:  kw_len = 4'd5;
				7:  kw_len = 4'd3;
				8:  kw_len = 4'd5;
				9:  kw_len = 4'd6;
				default: kw_len = 4'd4;
			endcase
		end
	endfunction

	// keyword text, byte i of keyword k, zero past its end
	function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
		logic [63:0] s;
		begin
			case (k)
				0:  s = "function";
				1:  s = "return";
				2:  s = "if";
				3:  s = "else";
				4:  s = "for";
				5:  s = "true";
				6:  s = "false";
				7:  s = "int";
				8:  s = "float";
				9:  s = "string";
				10: s = "bool";
				default: s = "void";
			endcase
			kw_char = (i < kw_len(k)) ? s[8*(kw_len(k)-1-i) +: 8] : 8'd0;
		end
	endfunction

	// one result before position is attached
	typedef struct packed {
		logic       valid;
		logic [1:0] rk;
		logic [5:0] tt;
		logic [1:0] pos_sel;   // 0 token start, 1 dot, 2 or 3 current
		logic [7:0] tb;
		logic       ec;
	} slot_t;
endpackage
`default_nettype wire

// File: hw/rtl/sbt_front.sv
// scanner state machine: classifies bytes and builds up to three results
`default_nettype none
module sbt_front #(
	parameter int PW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic          kind,
	input  wire logic [7:0]    source_byte,
	output logic [3:0]         n_res,
	output logic [3*(2+6+PW+PW+8+1+1+1)-1:0] res_bus
);
	import sbt_pkg::*;
	localparam int RW = 2+6+PW+PW+8+1+1+1;
	localparam logic [PW-1:0] PMAX = {PW{1'b1}};
	localparam logic [PW-1:0] ONE = PW'(1);

	localparam logic [3:0] M_IDLE = 4'd0, M_IDENT = 4'd1, M_NUM = 4'd2, M_NUMDOT = 4'd3,
		M_FRAC = 4'd4, M_STR = 4'd5, M_ESC = 4'd6, M_EQ = 4'd7, M_LT = 4'd8,
		M_GT = 4'd9, M_BANG = 4'd10;

	logic [3:0]    mode_q, mode_d;
	logic [PW-1:0] line_q, col_q, tline_q, tcol_q, dline_q, dcol_q;
	logic [PW-1:0] tline_d, tcol_d, dline_d, dcol_d;
	logic [11:0]   cand_q, cand_d;
	logic [3:0]    ilen_q, ilen_d;
	logic          err_q;
	slot_t         s [3];
	logic [1:0]    ns;

	logic is_dig, is_alp;
	assign is_dig = source_byte >= "0" && source_byte <= "9";
	assign is_alp = (source_byte >= "a" && source_byte <= "z") ||
		(source_byte >= "A" && source_byte <= "Z") || source_byte == "_";

	// keyword matching from a given mask and length
	function automatic logic [11:0] feed(input logic [11:0] c, input logic [3:0] i,
		input logic [7:0] b);
		logic [11:0] m;
		begin
			m = '0;
			for (int k = 0; k < NUM_KW; k++)
				if (c[k] && i < kw_len(k) && kw_char(k, i) == b) m[k] = 1'b1;
			feed = m;
		end
	endfunction

	function automatic logic [5:0] ident_type(input logic [11:0] c, input logic [3:0] l);
		logic [5:0] t;
		begin
			t = T_IDENT;
			for (int k = 0; k < NUM_KW; k++)
				if (c[k] && kw_len(k) == l) t = T_KW0 + 6'(k);
			ident_type = t;
		end
	endfunction

	// results from the closing of an open token keep the old start position
	function automatic logic idle_go_first(input slot_t x);
		begin
			idle_go_first = (mode_q != M_IDLE) && (mode_q <= M_BANG) && x.rk != RK_TEXT;
		end
	endfunction

	always_comb begin
		logic idle_go;
		logic [5:0] tok;
		for (int j = 0; j < 3; j++) s[j] = '0;
		ns = 2'd0;
		mode_d = mode_q; tline_d = tline_q; tcol_d = tcol_q;
		dline_d = dline_q; dcol_d = dcol_q; cand_d = cand_q; ilen_d = ilen_q;
		idle_go = 1'b0;
		tok = '0;
		if (kind) begin
			unique case (mode_q)
				M_IDENT: begin s[ns] = '{1'b1, RK_TOKEN, ident_type(cand_q, ilen_q), 2'd0, 8'd0, 1'b0}; ns++; end
				M_NUM: begin s[ns] = '{1'b1, RK_TOKEN, T_INT, 2'd0, 8'd0, 1'b0}; ns++; end
				M_NUMDOT: begin
					s[0] = '{1'b1, RK_TOKEN, T_INT, 2'd0, 8'd0, 1'b0};
					s[1] = '{1'b1, RK_ERROR, 6'd0, 2'd1, ".", EC_UNKNOWN}; ns = 2'd2;
				end
				M_FRAC: begin s[ns] = '{1'b1, RK_TOKEN, T_FLOAT, 2'd0, 8'd0, 1'b0}; ns++; end
				M_STR, M_ESC: begin s[ns] = '{1'b1, RK_ERROR, 6'd0, 2'd0, 8'h22, EC_UNTERM}; ns++; end
				M_EQ: begin s[ns] = '{1'b1, RK_TOKEN, T_ASSIGN, 2'd0, 8'd0, 1'b0}; ns++; end
				M_LT: begin s[ns] = '{1'b1, RK_TOKEN, T_LESS, 2'd0, 8'd0, 1'b0}; ns++; end
				M_GT: begin s[ns] = '{1'b1, RK_TOKEN, T_GREATER, 2'd0, 8'd0, 1'b0}; ns++; end
				M_BANG: begin s[ns] = '{1'b1, RK_ERROR, 6'd0, 2'd0, "!", EC_UNKNOWN}; ns++; end
				default: ;
			endcase
			s[ns] = '{1'b1, RK_TOKEN, T_EOF, 2'd3, 8'd0, 1'b0}; ns++;
		end else begin
			unique case (mode_q)
				M_IDENT: if (is_alp || is_dig) begin
					s[0] = '{1'b1, RK_TEXT, 6'd0, 2'd0, source_byte, 1'b0}; ns = 2'd1;
					cand_d = feed(cand_q, ilen_q, source_byte);
					if (ilen_q != 4'd15) ilen_d = ilen_q + 4'd1;
				end else begin
					s[0] = '{1'b1, RK_TOKEN, ident_type(cand_q, ilen_q), 2'd0, 8'd0, 1'b0};
					ns = 2'd1; idle_go = 1'b1;
				end
				M_NUM: if (is_dig) begin
					s[0] = '{1'b1, RK_TEXT, 6'd0, 2'd0, source_byte, 1'b0}; ns = 2'd1;
				end else if (source_byte == ".") begin
					dline_d = line_q; dcol_d = col_q; mode_d = M_NUMDOT;
				end else begin
					s[0] = '{1'b1, RK_TOKEN, T_INT, 2'd0, 8'd0, 1'b0}; ns = 2'd1; idle_go = 1'b1;
				end
				M_NUMDOT: if (is_dig) begin
					s[0] = '{1'b1, RK_TEXT, 6'd0, 2'd0, ".", 1'b0};
					s[1] = '{1'b1, RK_TEXT, 6'd0, 2'd0, source_byte, 1'b0};
					ns = 2'd2; mode_d = M_FRAC;
				end else begin
					s[0] = '{1'b1, RK_TOKEN, T_INT, 2'd0, 8'd0, 1'b0};
					s[1] = '{1'b1, RK_ERROR, 6'd0, 2'd1, ".", EC_UNKNOWN};
					ns = 2'd2; idle_go = 1'b1;
				end
				M_FRAC: if (is_dig) begin
					s[0] = '{1'b1, RK_TEXT, 6'd0, 2'd0, source_byte, 1'b0}; ns = 2'd1;
				end else begin
					s[0] = '{1'b1, RK_TOKEN, T_FLOAT, 2'd0, 8'd0, 1'b0}; ns = 2'd1; idle_go = 1'b1;
				end
				M_STR: if (source_byte == 8'h5c) mode_d = M_ESC;
				else if (source_byte == 8'h22) begin
					s[0] = '{1'b1, RK_TOKEN, T_STRING, 2'd0, 8'd0, 1'b0}; ns = 2'd1; mode_d = M_IDLE;
				end else begin
					s[0] = '{1'b1, RK_TEXT, 6'd0, 2'd0, source_byte, 1'b0}; ns = 2'd1;
				end
				M_ESC: begin
					s[0] = '{1'b1, RK_TEXT, 6'd0, 2'd0,
						source_byte == "n" ? 8'h0a : (source_byte == "t" ? 8'h09 : source_byte), 1'b0};
					ns = 2'd1; mode_d = M_STR;
				end
				M_EQ, M_LT, M_GT, M_BANG: begin
					if (source_byte == "=") begin
						tok = mode_q == M_EQ ? T_EQEQ : mode_q == M_LT ? T_LESSEQ :
							mode_q == M_GT ? T_GREATEREQ : T_BANGEQ;
						s[0] = '{1'b1, RK_TOKEN, tok, 2'd0, 8'd0, 1'b0}; mode_d = M_IDLE;
					end else if (mode_q == M_BANG) begin
						s[0] = '{1'b1, RK_ERROR, 6'd0, 2'd0, "!", EC_UNKNOWN}; idle_go = 1'b1;
					end else begin
						tok = mode_q == M_EQ ? T_ASSIGN : mode_q == M_LT ? T_LESS : T_GREATER;
						s[0] = '{1'b1, RK_TOKEN, tok, 2'd0, 8'd0, 1'b0}; idle_go = 1'b1;
					end
					ns = 2'd1;
				end
				default: idle_go = 1'b1;
			endcase
			if (idle_go) begin
				tline_d = line_q; tcol_d = col_q; mode_d = M_IDLE;
				case (source_byte)
					"(", ")", "{", "}", ":", ",", "+", "-", "*", "/": begin
						case (source_byte)
							"(": tok = 6'd0; ")": tok = 6'd1; "{": tok = 6'd2; "}": tok = 6'd3;
							":": tok = 6'd4; ",": tok = 6'd5; "+": tok = 6'd6; "-": tok = 6'd7;
							"*": tok = 6'd8; default: tok = 6'd9;
						endcase
						s[ns] = '{1'b1, RK_TOKEN, tok, 2'd0, 8'd0, 1'b0}; ns++;
					end
					"=": mode_d = M_EQ;
					"<": mode_d = M_LT;
					">": mode_d = M_GT;
					"!": mode_d = M_BANG;
					8'h22: mode_d = M_STR;
					" ", 8'h0d, 8'h09, 8'h0a: ;
					default: if (is_dig) begin
						mode_d = M_NUM;
						s[ns] = '{1'b1, RK_TEXT, 6'd0, 2'd0, source_byte, 1'b0}; ns++;
					end else if (is_alp) begin
						mode_d = M_IDENT;
						cand_d = feed(12'hfff, 4'd0, source_byte); ilen_d = 4'd1;
						s[ns] = '{1'b1, RK_TEXT, 6'd0, 2'd0, source_byte, 1'b0}; ns++;
					end else begin
						s[ns] = '{1'b1, RK_ERROR, 6'd0, 2'd0, source_byte, EC_UNKNOWN}; ns++;
					end
				endcase
			end
		end
	end

	// attach positions and sticky error flag
	always_comb begin
		logic e;
		logic [PW-1:0] ln, cl;
		e = err_q;
		res_bus = '0;
		for (int j = 0; j < 3; j++) begin
			case (s[j].pos_sel)
				2'd0: begin ln = tline_d; cl = tcol_d; end
				2'd1: begin ln = dline_q; cl = dcol_q; end
				default: begin ln = line_q; cl = col_q; end
			endcase
			if (s[j].pos_sel == 2'd0 && s[j].rk == RK_ERROR && s[j].tb == 8'h22) begin
				ln = tline_q; cl = tcol_q;
			end
			if (s[j].pos_sel == 2'd0 && !kind && s[j].rk == RK_ERROR && s[j].tb == "!" &&
				mode_q == M_BANG && j == 0) begin
				ln = tline_q; cl = tcol_q;
			end
			if (s[j].pos_sel == 2'd0 && j == 0 && !kind && idle_go_first(s[j])) begin
				ln = tline_q; cl = tcol_q;
			end
			if (s[j].valid && s[j].rk == RK_ERROR) e = 1'b1;
			res_bus[j*RW +: RW] = {s[j].rk, s[j].tt, ln, cl, s[j].tb, s[j].ec, e,
				(2'(j) == ns - 2'd1)};
		end
	end

	assign n_res = {2'b00, ns};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; line_q <= ONE; col_q <= ONE; tline_q <= ONE; tcol_q <= ONE;
			dline_q <= ONE; dcol_q <= ONE; cand_q <= '0; ilen_q <= '0; err_q <= 1'b0;
		end else if (take) begin
			if (kind) begin
				mode_q <= M_IDLE; line_q <= ONE; col_q <= ONE; tline_q <= ONE; tcol_q <= ONE;
				dline_q <= ONE; dcol_q <= ONE; cand_q <= '0; ilen_q <= '0; err_q <= 1'b0;
			end else begin
				mode_q <= mode_d; tline_q <= tline_d; tcol_q <= tcol_d;
				dline_q <= dline_d; dcol_q <= dcol_d; cand_q <= cand_d; ilen_q <= ilen_d;
				for (int j = 0; j < 3; j++)
					if (s[j].valid && s[j].rk == RK_ERROR) err_q <= 1'b1;
				if (source_byte == 8'h0a) begin
					if (line_q != PMAX) line_q <= line_q + ONE;
					col_q <= ONE;
				end else if (col_q != PMAX) col_q <= col_q + ONE;
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/sbt_back.sv
// result queue: takes up to three results per cycle, hands out one per pop
`default_nettype none
module sbt_back #(
	parameter int RW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire logic [3:0]    n_in,
	input  wire logic [3*RW-1:0] din,
	output logic               full,
	output logic               empty,
	input  wire logic          pop,
	output logic [RW-1:0]      dout
);
	localparam int D = 8;
	logic [RW-1:0] mem_q [D];
	logic [2:0]    rp_q, wp_q;
	logic [3:0]    cnt_q;
	logic          do_pop;

	assign empty  = cnt_q == 4'd0;
	assign full   = cnt_q > 4'd5;
	assign dout   = mem_q[rp_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			for (int j = 0; j < 3; j++)
				if (4'(j) < n_in) mem_q[wp_q + 3'(j)] <= din[j*RW +: RW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0; wp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + n_in[2:0];
			if (do_pop) rp_q <= rp_q + 3'd1;
			cnt_q <= cnt_q + (wr ? n_in : 4'd0) - {3'd0, do_pop};
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/source_byte_tokenizer_top.sv
// top level of the streaming source byte tokenizer
// usage:
//   input channel: drive kind and source_byte with push; an item is taken at
//   a clock edge with push high and full low. kind 1 marks end of source
//   result channel: while empty is low the oldest result sits on the result
//   ports; pop takes it. each item gives zero to three results, the last
//   one flagged by is_last
// throughput: one item per cycle while full is low; the scanner is
//   a single state register, so every byte is classified in the
//   cycle it is taken, and its results enter the queue as it is taken
// a scanner front writes results into an eight entry queue; full rises
//   once fewer than three slots remain, so a stalled receiver holds
//   the input side back without losing results
// reset clears the scanner (line and column 1) and empties the queue;
//   the end marker returns the scanner to the same state
`default_nettype none
module source_byte_tokenizer_top #(
	parameter int POSITION_WIDTH = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic                      kind,
	input  wire logic [7:0]                source_byte,
	output logic                           empty,
	input  wire logic                      pop,
	output logic [1:0]                     result_kind,
	output logic [5:0]                     token_type,
	output logic [POSITION_WIDTH-1:0]      start_line,
	output logic [POSITION_WIDTH-1:0]      start_column,
	output logic [7:0]                     text_byte,
	output logic                           error_code,
	output logic                           any_error,
	output logic                           is_last
);
	localparam int RW = 2+6+POSITION_WIDTH+POSITION_WIDTH+8+1+1+1;
	logic          take;
	logic [3:0]    n_res;
	logic [3*RW-1:0] res_bus;
	logic [RW-1:0] head;

	assign take = push && !full;

	sbt_front #(.PW(POSITION_WIDTH)) u_front (
		.clk, .arst_n, .take, .kind, .source_byte, .n_res, .res_bus
	);

	sbt_back #(.RW(RW)) u_back (
		.clk, .arst_n, .wr(take), .n_in(n_res), .din(res_bus),
		.full, .empty, .pop, .dout(head)
	);

	assign {result_kind, token_type, start_line, start_column, text_byte, error_code,
		any_error, is_last} = head;
endmodule
`default_nettype wire

// File: dv/source_byte_tokenizer_top_tb.sv
// self-checking testbench for the source byte tokenizer top level
`timescale 1ns / 100ps
`default_nettype none
module source_byte_tokenizer_top_tb;
	import sbt_pkg::*;

	localparam int PW = 16;
	localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
	localparam int CYCLE_LIMIT = 400000;

	// scanner modes of the predictor
	typedef enum logic [3:0] {
		SM_IDLE, SM_IDENT, SM_NUM, SM_NUMDOT, SM_FRAC, SM_STR, SM_ESC,
		SM_EQ, SM_LT, SM_GT, SM_BANG
	} scan_mode_e;

	typedef struct packed {
		logic [1:0]    rk;
		logic [5:0]    tt;
		logic [PW-1:0] ln;
		logic [PW-1:0] col;
		logic [7:0]    tb;
		logic          ec;
		logic          err;
		logic          last;
	} token_result_t;

	// scoreboard: predicts tokenizer results and compares them in order
	class token_scoreboard;
		scan_mode_e    mode;
		logic [PW-1:0] line_no, col_no, tok_line, tok_col, dot_line, dot_col;
		logic [11:0]   kw_mask;
		logic [3:0]    id_len;
		logic          err_seen;
		token_result_t pending[$];
		token_result_t step_out[$];
		int            mismatches;

		function new();
			mismatches = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			mode = SM_IDLE;
			line_no = 1; col_no = 1; tok_line = 1; tok_col = 1;
			dot_line = 1; dot_col = 1;
			kw_mask = '0; id_len = '0; err_seen = 1'b0;
		endfunction

		// at most three results per item
		function void put(logic [1:0] rk, logic [5:0] tt, logic [PW-1:0] ln,
				logic [PW-1:0] col, logic [7:0] tb, logic ec);
			token_result_t r;
			if (step_out.size() >= 3) return;
			if (rk == RK_ERROR) err_seen = 1'b1;
			r.rk = rk; r.tt = tt; r.ln = ln; r.col = col; r.tb = tb; r.ec = ec;
			r.err = err_seen; r.last = 1'b0;
			step_out = {step_out, r};
		endfunction

		function void put_text(logic [7:0] b);
			put(RK_TEXT, 6'd0, tok_line, tok_col, b, 1'b0);
		endfunction

		function void put_token(logic [5:0] t);
			put(RK_TOKEN, t, tok_line, tok_col, 8'd0, 1'b0);
		endfunction

		function automatic bit is_digit(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function automatic bit is_alpha(logic [7:0] b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
		endfunction

		// keyword text held locally, one string per keyword
		function automatic logic [7:0] keyword_byte(int k, int i);
			string words[12] = '{"function", "return", "if", "else", "for", "true",
				"false", "int", "float", "string", "bool", "void"};
			if (i >= words[k].len()) return 8'd0;
			return words[k][i];
		endfunction

		function automatic int keyword_len(int k);
			string words[12] = '{"function", "return", "if", "else", "for", "true",
				"false", "int", "float", "string", "bool", "void"};
			return words[k].len();
		endfunction

		function void narrow_keywords(logic [7:0] b);
			logic [11:0] m;
			m = '0;
			for (int k = 0; k < 12; k++)
				if (kw_mask[k] && id_len < keyword_len(k) && keyword_byte(k, id_len) == b)
					m[k] = 1'b1;
			kw_mask = m;
			if (id_len < 4'd15) id_len++;
		endfunction

		function void close_ident();
			logic [5:0] t;
			t = T_IDENT;
			for (int k = 0; k < 12; k++)
				if (kw_mask[k] && keyword_len(k) == id_len) t = T_KW0 + 6'(k);
			put_token(t);
		endfunction

		function void scan_idle(logic [7:0] b, logic [PW-1:0] ln, logic [PW-1:0] col);
			tok_line = ln; tok_col = col;
			mode = SM_IDLE;
			case (b)
				"(": put_token(6'd0);
				")": put_token(6'd1);
				"{": put_token(6'd2);
				"}": put_token(6'd3);
				":": put_token(6'd4);
				",": put_token(6'd5);
				"+": put_token(6'd6);
				"-": put_token(6'd7);
				"*": put_token(6'd8);
				"/": put_token(6'd9);
				"=": mode = SM_EQ;
				"<": mode = SM_LT;
				">": mode = SM_GT;
				"!": mode = SM_BANG;
				"\"": mode = SM_STR;
				" ", 8'h0d, 8'h09, 8'h0a: ;
				default: begin
					if (is_digit(b)) begin
						mode = SM_NUM;
						put_text(b);
					end else if (is_alpha(b)) begin
						mode = SM_IDENT;
						kw_mask = '1;
						id_len = '0;
						narrow_keywords(b);
						put_text(b);
					end else begin
						put(RK_ERROR, 6'd0, ln, col, b, EC_UNKNOWN);
					end
				end
			endcase
		endfunction

		function void close_op(logic [7:0] b, logic [PW-1:0] ln, logic [PW-1:0] col,
				logic [5:0] with_eq, logic [5:0] alone);
			if (b == "=") begin
				put_token(with_eq);
				mode = SM_IDLE;
			end else begin
				put_token(alone);
				scan_idle(b, ln, col);
			end
		endfunction

		// note an accepted input item and queue what it should produce
		function void note_item(logic kind, logic [7:0] b);
			logic [PW-1:0] ln, col;
			ln = line_no; col = col_no;
			step_out.delete();
			if (kind) begin
				case (mode)
					SM_IDENT: close_ident();
					SM_NUM: put_token(T_INT);
					SM_NUMDOT: begin
						put_token(T_INT);
						put(RK_ERROR, 6'd0, dot_line, dot_col, ".", EC_UNKNOWN);
					end
					SM_FRAC: put_token(T_FLOAT);
					SM_STR, SM_ESC: put(RK_ERROR, 6'd0, tok_line, tok_col, "\"", EC_UNTERM);
					SM_EQ: put_token(T_ASSIGN);
					SM_LT: put_token(T_LESS);
					SM_GT: put_token(T_GREATER);
					SM_BANG: put(RK_ERROR, 6'd0, tok_line, tok_col, "!", EC_UNKNOWN);
					default: ;
				endcase
				put(RK_TOKEN, T_EOF, line_no, col_no, 8'd0, 1'b0);
				clear_scan();
			end else begin
				// position advances before the byte is scanned
				if (b == 8'h0a) begin
					if (line_no < POS_MAX) line_no++;
					col_no = 1;
				end else if (col_no < POS_MAX) begin
					col_no++;
				end
				case (mode)
					SM_IDENT: begin
						if (is_alpha(b) || is_digit(b)) begin
							put_text(b);
							narrow_keywords(b);
						end else begin
							close_ident();
							scan_idle(b, ln, col);
						end
					end
					SM_NUM: begin
						if (is_digit(b)) put_text(b);
						else if (b == ".") begin
							dot_line = ln; dot_col = col; mode = SM_NUMDOT;
						end else begin
							put_token(T_INT);
							scan_idle(b, ln, col);
						end
					end
					SM_NUMDOT: begin
						if (is_digit(b)) begin
							put_text(".");
							put_text(b);
							mode = SM_FRAC;
						end else begin
							put_token(T_INT);
							put(RK_ERROR, 6'd0, dot_line, dot_col, ".", EC_UNKNOWN);
							scan_idle(b, ln, col);
						end
					end
					SM_FRAC: begin
						if (is_digit(b)) put_text(b);
						else begin
							put_token(T_FLOAT);
							scan_idle(b, ln, col);
						end
					end
					SM_STR: begin
						if (b == "\\") mode = SM_ESC;
						else if (b == "\"") begin
							put_token(T_STRING);
							mode = SM_IDLE;
						end else put_text(b);
					end
					SM_ESC: begin
						put_text(b == "n" ? 8'h0a : (b == "t" ? 8'h09 : b));
						mode = SM_STR;
					end
					SM_EQ: close_op(b, ln, col, T_EQEQ, T_ASSIGN);
					SM_LT: close_op(b, ln, col, T_LESSEQ, T_LESS);
					SM_GT: close_op(b, ln, col, T_GREATEREQ, T_GREATER);
					SM_BANG: begin
						if (b == "=") begin
							put_token(T_BANGEQ);
							mode = SM_IDLE;
						end else begin
							put(RK_ERROR, 6'd0, tok_line, tok_col, "!", EC_UNKNOWN);
							scan_idle(b, ln, col);
						end
					end
					default: scan_idle(b, ln, col);
				endcase
			end
			if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
			pending = {pending, step_out};
		endfunction

		// compare one popped result against the oldest expectation
		function void check_result(token_result_t got);
			token_result_t exp;
			if (pending.size() == 0) begin
				$error("result with nothing expected: kind %0d type %0d", got.rk, got.tt);
				mismatches++;
				return;
			end
			exp = pending.pop_front();
			if (got.rk !== exp.rk) begin
				$error("result_kind: expected %0d, got %0d", exp.rk, got.rk); mismatches++;
			end
			if (got.tt !== exp.tt) begin
				$error("token_type: expected %0d, got %0d", exp.tt, got.tt); mismatches++;
			end
			if (got.ln !== exp.ln) begin
				$error("start_line: expected %0d, got %0d", exp.ln, got.ln); mismatches++;
			end
			if (got.col !== exp.col) begin
				$error("start_column: expected %0d, got %0d", exp.col, got.col); mismatches++;
			end
			if (got.tb !== exp.tb) begin
				$error("text_byte: expected %0h, got %0h", exp.tb, got.tb); mismatches++;
			end
			if (got.ec !== exp.ec) begin
				$error("error_code: expected %0d, got %0d", exp.ec, got.ec); mismatches++;
			end
			if (got.err !== exp.err) begin
				$error("any_error: expected %0d, got %0d", exp.err, got.err); mismatches++;
			end
			if (got.last !== exp.last) begin
				$error("is_last: expected %0d, got %0d", exp.last, got.last); mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic kind = 1'b0;
	logic [7:0] source_byte = 8'd0;
	logic pop = 1'b0;
	logic full, empty;
	logic [1:0] result_kind;
	logic [5:0] token_type;
	logic [PW-1:0] start_line, start_column;
	logic [7:0] text_byte;
	logic error_code, any_error, is_last;

	source_byte_tokenizer_top #(.POSITION_WIDTH(PW)) dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .kind(kind), .source_byte(source_byte),
		.empty(empty), .pop(pop),
		.result_kind(result_kind), .token_type(token_type),
		.start_line(start_line), .start_column(start_column),
		.text_byte(text_byte), .error_code(error_code),
		.any_error(any_error), .is_last(is_last)
	);

	always #5 clk = ~clk;

	token_scoreboard sb = new();
	int cycle_count = 0;
	bit sink_hold = 1'b0;     // long receiver hold-off while set
	int hold_cycles = 0;

	// source items waiting to be pushed
	logic [8:0] source_items[$];

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic queue_item(logic [8:0] it);
		source_items = {source_items, it};
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) queue_item({1'b0, 8'(s[i])});
	endtask

	task automatic add_end();
		queue_item({1'b1, 8'(($urandom_range(0, 255)))});
	endtask

	// push every queued item; gaps only in phases that allow them
	task automatic send_items(bit with_gaps);
		logic [8:0] it;
		int g;
		while (source_items.size() > 0) begin
			it = source_items.pop_front();
			g = with_gaps ? gap_len() : 0;
			if (g > 0) begin
				push <= 1'b0;
				repeat (g) @(negedge clk);
			end
			push <= 1'b1;
			kind <= it[8];
			source_byte <= it[7:0];
			do @(posedge clk); while (full);
			sb.note_item(it[8], it[7:0]);
			@(negedge clk);
		end
		push <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (sb.pending.size() > 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// random lexeme with well-formed content, occasionally malformed
	task automatic add_random_lexeme();
		string kws[12] = '{"function", "return", "if", "else", "for", "true",
			"false", "int", "float", "string", "bool", "void"};
		string ops[17] = '{"(", ")", "{", "}", ":", ",", "+", "-", "*", "/",
			"=", "==", "!=", "<", "<=", ">", ">="};
		int sel, n;
		sel = $urandom_range(0, 99);
		if (sel < 15) add_text(kws[$urandom_range(0, 11)]);
		else if (sel < 30) begin
			n = $urandom_range(1, 18);
			for (int i = 0; i < n; i++)
				queue_item({1'b0, 8'("a" + $urandom_range(0, 25))});
		end else if (sel < 45) begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				queue_item({1'b0, 8'("0" + $urandom_range(0, 9))});
			if ($urandom_range(0, 2) == 0) begin
				add_text(".");
				if ($urandom_range(0, 3) != 0)
					queue_item({1'b0, 8'("0" + $urandom_range(0, 9))});
			end
		end else if (sel < 60) add_text(ops[$urandom_range(0, 16)]);
		else if (sel < 72) begin
			add_text("\"");
			n = $urandom_range(0, 5);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 4) == 0) add_text("\\");
				queue_item({1'b0, 8'($urandom_range(32, 126))});
			end
			if ($urandom_range(0, 5) != 0) add_text("\"");
		end else if (sel < 85) begin
			case ($urandom_range(0, 3))
				0: add_text(" ");
				1: add_text("\n");
				2: add_text("\t");
				default: queue_item({1'b0, 8'h0d});
			endcase
		end else begin
			// noise: any byte at all
			queue_item({1'b0, 8'($urandom_range(0, 255))});
		end
		if ($urandom_range(0, 2) == 0) add_text(" ");
	endtask

	// result side: random pop stalls plus the long hold-off
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			g = gap_len();
			if (sink_hold || g > 0) begin
				pop <= 1'b0;
				repeat (g) @(negedge clk);
				while (sink_hold) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			if (!empty)
				sb.check_result('{result_kind, token_type, start_line, start_column,
					text_byte, error_code, any_error, is_last});
		end
	end

	// watchdog on a cycle counter
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int sent;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: every operator, keywords, literals and the named corner cases
		add_text("( ) { } : , + - * / = == != < <= > >= ");
		add_text("function return if else for true false int float string bool void ");
		add_text("functions x_9 abcdefghijklmnopqrs 12 3.5 7.x 4. ");
		add_text("\"a\\n\\t\\\"\\\\\\q\" !x ! @");
		queue_item({1'b0, 8'hff});
		queue_item({1'b0, 8'h80});
		add_text("\n\"open");
		add_end();
		send_items(1'b0);
		wait_drained();

		// pending operators, number-dot, escape, float and keyword flushed by end markers
		add_text("="); add_end();
		add_text("<"); add_end();
		add_text(">"); add_end();
		add_text("!"); add_end();
		add_text("9."); add_end();
		add_text("\"\\"); add_end();
		add_text("2.25"); add_end();
		add_text("if"); add_end();
		add_end();
		send_items(1'b1);

		// receiver holds off while the sender keeps pushing, filling the queue
		sink_hold = 1'b1;
		fork
			begin
				hold_cycles = 0;
				while (hold_cycles < 60) begin
					@(negedge clk);
					hold_cycles++;
				end
				sink_hold = 1'b0;
			end
			begin
				for (int i = 0; i < 30; i++) add_text("(");
				send_items(1'b0);
			end
		join
		wait_drained();

		// random programs, ended now and then
		sent = 0;
		while (sent < 110) begin
			add_random_lexeme();
			if ($urandom_range(0, 39) == 0) add_end();
			sent += source_items.size();
			send_items(1'b1);
		end
		add_end();
		send_items(1'b1);

		while (sb.pending.size() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
